// ----- hdl/tam_pkg.sv -----
// shared types and constants for the tensor anisotropy measure block
package tam_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W = 32;
  localparam int SEL_W = 4;

  localparam logic [SEL_W-1:0] SEL_FA   = 4'd0;
  localparam logic [SEL_W-1:0] SEL_RA   = 4'd1;
  localparam logic [SEL_W-1:0] SEL_CL   = 4'd2;
  localparam logic [SEL_W-1:0] SEL_CP   = 4'd3;
  localparam logic [SEL_W-1:0] SEL_CS   = 4'd4;
  localparam logic [SEL_W-1:0] SEL_CA   = 4'd5;
  localparam logic [SEL_W-1:0] SEL_MD   = 4'd6;
  localparam logic [SEL_W-1:0] SEL_EIG1 = 4'd7;
  localparam logic [SEL_W-1:0] SEL_EIG2 = 4'd8;
  localparam logic [SEL_W-1:0] SEL_EIG3 = 4'd9;

  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_DIV,
    KIND_SQRT
  } tam_kind_e;

  typedef struct packed {
    logic              valid;
    logic              neg;
    tam_kind_e         kind;
    logic [DATA_W-1:0] direct;
  } tam_side_t;

endpackage

// ----- hdl/tam_div_cell.sv -----
// one restoring division cell, one quotient bit per cycle while en_i is high
module tam_div_cell import tam_pkg::*; #(
  parameter int NUMW = 97,
  parameter int DENW = 66
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  tam_side_t       side_i,
  input  logic [NUMW-1:0] num_i,
  input  logic [DENW-1:0] den_i,
  input  logic [DENW-1:0] rem_i,
  input  logic [NUMW-1:0] quo_i,
  output tam_side_t       side_o,
  output logic [NUMW-1:0] num_o,
  output logic [DENW-1:0] den_o,
  output logic [DENW-1:0] rem_o,
  output logic [NUMW-1:0] quo_o
);

  logic [DENW:0]   rem_n;
  logic [DENW:0]   diff;
  logic            ge;
  tam_side_t       side_q;
  logic [NUMW-1:0] num_q, quo_q;
  logic [DENW-1:0] den_q, rem_q;

  always_comb begin
    rem_n = {rem_i, num_i[NUMW-1]};
    ge    = rem_n >= {1'b0, den_i};
    diff  = rem_n - {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= {num_i[NUMW-2:0], 1'b0};
      den_q <= den_i;
      rem_q <= ge ? diff[DENW-1:0] : rem_n[DENW-1:0];
      quo_q <= {quo_i[NUMW-2:0], ge};
    end
  end

  assign side_o = side_q;
  assign num_o  = num_q;
  assign den_o  = den_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;

endmodule

// ----- hdl/tam_sqrt_cell.sv -----
// one digit-by-digit square root cell, one root bit per cycle while en_i is high
module tam_sqrt_cell import tam_pkg::*; #(
  parameter int RW = 49
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  tam_side_t       side_i,
  input  logic [2*RW-1:0] x_i,
  input  logic [RW-1:0]   root_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [DATA_W:0] pass_i,
  output tam_side_t       side_o,
  output logic [2*RW-1:0] x_o,
  output logic [RW-1:0]   root_o,
  output logic [RW+1:0]   rem_o,
  output logic [DATA_W:0] pass_o
);

  logic [RW+3:0]   rem_n, trial, diff;
  logic            ge;
  tam_side_t       side_q;
  logic [2*RW-1:0] x_q;
  logic [RW-1:0]   root_q;
  logic [RW+1:0]   rem_q;
  logic [DATA_W:0] pass_q;

  always_comb begin
    rem_n = {rem_i, x_i[2*RW-1:2*RW-2]};
    trial = {2'b00, root_i, 2'b01};
    ge    = rem_n >= trial;
    diff  = rem_n - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= {x_i[2*RW-3:0], 2'b00};
      root_q <= {root_i[RW-2:0], ge};
      rem_q  <= ge ? diff[RW+1:0] : rem_n[RW+1:0];
      pass_q <= pass_i;
    end
  end

  assign side_o = side_q;
  assign x_o    = x_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;
  assign pass_o = pass_q;

endmodule

// ----- hdl/tensor_anisotropy_measure.sv -----
// top level: anisotropy measures from three sorted eigenvalues
// stages: three front stages, one cell per quotient bit, one cell per root bit,
// one output register; NUMW = 65 + 2*FRAC_BITS and RW = (NUMW+1)/2
// throughput: one item per cycle while the output skid is empty; the divider and
// root chains, like every stage, advance only while the skid is empty
// reset clears the valid bits of every stage and the output skid, and selects SEL_FA
module tensor_anisotropy_measure import tam_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [SEL_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DATA_W-1:0] eigen_first_i,
  input  logic signed [DATA_W-1:0] eigen_second_i,
  input  logic signed [DATA_W-1:0] eigen_third_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DATA_W-1:0] measure_value_o,
  output logic                    saturated_o
);

  localparam int NUMW = 65 + 2 * FRAC_BITS;
  localparam int DENW = 66;
  localparam int RW = (NUMW + 1) / 2;
  localparam int XW = 2 * RW;

  logic en;
  logic [SEL_W-1:0] sel_q;

  // config register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= SEL_FA;
    end else if (cfg_valid_i) begin
      sel_q <= cfg_data_i;
    end
  end

  // stage 1: input register
  logic                     p1_valid_q;
  logic signed [DATA_W-1:0] p1_a_q, p1_b_q, p1_c_q;
  logic [SEL_W-1:0]         p1_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_a_q   <= eigen_first_i;
      p1_b_q   <= eigen_second_i;
      p1_c_q   <= eigen_third_i;
      p1_sel_q <= sel_q;
    end
  end

  // stage 2: sums, differences, magnitudes
  logic signed [33:0] t2;
  logic signed [32:0] dba, dcb, dca;
  logic signed [35:0] sn, c3;
  logic               tz, d0;
  tam_side_t          side2;

  always_comb begin
    t2  = 34'(p1_a_q) + 34'(p1_b_q) + 34'(p1_c_q);
    dba = 33'(p1_b_q) - 33'(p1_a_q);
    dcb = 33'(p1_c_q) - 33'(p1_b_q);
    dca = 33'(p1_c_q) - 33'(p1_a_q);
    c3  = (36'(p1_c_q) <<< 1) + 36'(p1_c_q);
    tz  = (t2 == '0);
    d0  = (p1_a_q == '0) && (p1_b_q == '0) && (p1_c_q == '0);
    side2.valid  = p1_valid_q;
    side2.neg    = 1'b0;
    side2.kind   = KIND_DIRECT;
    side2.direct = '0;
    sn = 36'(t2);
    case (p1_sel_q)
      SEL_FA: begin
        side2.kind = d0 ? KIND_DIRECT : KIND_SQRT;
      end
      SEL_RA: begin
        side2.kind = tz ? KIND_DIRECT : KIND_SQRT;
        side2.neg  = t2[33];
      end
      SEL_CL: begin
        sn = 36'(p1_a_q) - 36'(p1_b_q);
        side2.kind = tz ? KIND_DIRECT : KIND_DIV;
        side2.neg  = sn[35] ^ t2[33];
      end
      SEL_CP: begin
        sn = (36'(p1_b_q) - 36'(p1_c_q)) <<< 1;
        side2.kind = tz ? KIND_DIRECT : KIND_DIV;
        side2.neg  = sn[35] ^ t2[33];
      end
      SEL_CS: begin
        sn = c3;
        side2.kind = tz ? KIND_DIRECT : KIND_DIV;
        side2.neg  = sn[35] ^ t2[33];
      end
      SEL_CA: begin
        sn = 36'(t2) - c3;
        side2.kind   = tz ? KIND_DIRECT : KIND_DIV;
        side2.neg    = sn[35] ^ t2[33];
        side2.direct = 32'(1) << FRAC_BITS;
      end
      SEL_MD: begin
        side2.kind = KIND_DIV;
        side2.neg  = t2[33];
      end
      SEL_EIG1: side2.direct = p1_a_q;
      SEL_EIG2: side2.direct = p1_b_q;
      SEL_EIG3: side2.direct = p1_c_q;
      default: side2.direct = '0;
    endcase
  end

  tam_side_t        p2_side_q;
  logic [SEL_W-1:0] p2_sel_q;
  logic [31:0]      p2_ma_q, p2_mb_q, p2_mc_q;
  logic [32:0]      p2_mba_q, p2_mcb_q, p2_mca_q, p2_mt_q;
  logic [34:0]      p2_smag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_side_q <= '0;
    end else if (en) begin
      p2_side_q <= side2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_sel_q  <= p1_sel_q;
      p2_ma_q   <= p1_a_q[31] ? 32'(-p1_a_q) : 32'(p1_a_q);
      p2_mb_q   <= p1_b_q[31] ? 32'(-p1_b_q) : 32'(p1_b_q);
      p2_mc_q   <= p1_c_q[31] ? 32'(-p1_c_q) : 32'(p1_c_q);
      p2_mba_q  <= dba[32] ? 33'(-dba) : 33'(dba);
      p2_mcb_q  <= dcb[32] ? 33'(-dcb) : 33'(dcb);
      p2_mca_q  <= dca[32] ? 33'(-dca) : 33'(dca);
      p2_mt_q   <= t2[33] ? 33'(-t2) : 33'(t2);
      p2_smag_q <= sn[35] ? 35'(-sn) : 35'(sn);
    end
  end

  // stage 3: squares
  tam_side_t        p3_side_q;
  logic [SEL_W-1:0] p3_sel_q;
  logic [63:0]      p3_sqa_q, p3_sqb_q, p3_sqc_q;
  logic [65:0]      p3_sqba_q, p3_sqcb_q, p3_sqca_q, p3_sqt_q;
  logic [32:0]      p3_mt_q;
  logic [34:0]      p3_smag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_side_q <= '0;
    end else if (en) begin
      p3_side_q <= p2_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_sel_q  <= p2_sel_q;
      p3_sqa_q  <= 64'(p2_ma_q) * 64'(p2_ma_q);
      p3_sqb_q  <= 64'(p2_mb_q) * 64'(p2_mb_q);
      p3_sqc_q  <= 64'(p2_mc_q) * 64'(p2_mc_q);
      p3_sqba_q <= 66'(p2_mba_q) * 66'(p2_mba_q);
      p3_sqcb_q <= 66'(p2_mcb_q) * 66'(p2_mcb_q);
      p3_sqca_q <= 66'(p2_mca_q) * 66'(p2_mca_q);
      p3_sqt_q  <= 66'(p2_mt_q) * 66'(p2_mt_q);
      p3_mt_q   <= p2_mt_q;
      p3_smag_q <= p2_smag_q;
    end
  end

  // numerator and denominator for the divider chain
  logic [DENW-1:0] d_sum, s_sum, den0;
  logic [NUMW-1:0] num0;

  always_comb begin
    d_sum = 66'(p3_sqa_q) + 66'(p3_sqb_q) + 66'(p3_sqc_q);
    s_sum = p3_sqba_q + p3_sqcb_q + p3_sqca_q;
    num0  = NUMW'(p3_smag_q) << FRAC_BITS;
    den0  = 66'(p3_mt_q);
    case (p3_sel_q)
      SEL_FA: begin
        num0 = NUMW'(s_sum) << (2 * FRAC_BITS - 1);
        den0 = d_sum;
      end
      SEL_RA: begin
        num0 = NUMW'(s_sum) << (2 * FRAC_BITS - 1);
        den0 = p3_sqt_q;
      end
      SEL_MD: begin
        num0 = NUMW'(p3_smag_q);
        den0 = 66'd3;
      end
      default: ;
    endcase
  end

  // divider chain
  tam_side_t       dv_side [0:NUMW];
  logic [NUMW-1:0] dv_num  [0:NUMW];
  logic [DENW-1:0] dv_den  [0:NUMW];
  logic [DENW-1:0] dv_rem  [0:NUMW];
  logic [NUMW-1:0] dv_quo  [0:NUMW];

  assign dv_side[0] = p3_side_q;
  assign dv_num[0]  = num0;
  assign dv_den[0]  = den0;
  assign dv_rem[0]  = '0;
  assign dv_quo[0]  = '0;

  for (genvar i = 0; i < NUMW; i++) begin : g_div
    tam_div_cell #(.NUMW(NUMW), .DENW(DENW)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .side_i(dv_side[i]),
      .num_i (dv_num[i]),
      .den_i (dv_den[i]),
      .rem_i (dv_rem[i]),
      .quo_i (dv_quo[i]),
      .side_o(dv_side[i+1]),
      .num_o (dv_num[i+1]),
      .den_o (dv_den[i+1]),
      .rem_o (dv_rem[i+1]),
      .quo_o (dv_quo[i+1])
    );
  end

  // square root chain
  tam_side_t       sq_side [0:RW];
  logic [XW-1:0]   sq_x    [0:RW];
  logic [RW-1:0]   sq_root [0:RW];
  logic [RW+1:0]   sq_rem  [0:RW];
  logic [DATA_W:0] sq_pass [0:RW];

  assign sq_side[0] = dv_side[NUMW];
  assign sq_x[0]    = XW'(dv_quo[NUMW]);
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_pass[0] = {|dv_quo[NUMW][NUMW-1:DATA_W], dv_quo[NUMW][DATA_W-1:0]};

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    tam_sqrt_cell #(.RW(RW)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .side_i(sq_side[j]),
      .x_i   (sq_x[j]),
      .root_i(sq_root[j]),
      .rem_i (sq_rem[j]),
      .pass_i(sq_pass[j]),
      .side_o(sq_side[j+1]),
      .x_o   (sq_x[j+1]),
      .root_o(sq_root[j+1]),
      .rem_o (sq_rem[j+1]),
      .pass_o(sq_pass[j+1])
    );
  end

  // sign and clamp
  tam_side_t         fin;
  logic              big;
  logic [DATA_W-1:0] low, res_val;
  logic              res_sat;

  always_comb begin
    fin = sq_side[RW];
    if (fin.kind == KIND_SQRT) begin
      big = |sq_root[RW][RW-1:DATA_W];
      low = sq_root[RW][DATA_W-1:0];
    end else begin
      big = sq_pass[RW][DATA_W];
      low = sq_pass[RW][DATA_W-1:0];
    end
    if (fin.kind == KIND_DIRECT) begin
      res_sat = 1'b0;
      res_val = fin.direct;
    end else if (fin.neg) begin
      res_sat = big | (low[DATA_W-1] & |low[DATA_W-2:0]);
      res_val = res_sat ? {1'b1, {(DATA_W-1){1'b0}}} : DATA_W'(-low);
    end else begin
      res_sat = big | low[DATA_W-1];
      res_val = res_sat ? {1'b0, {(DATA_W-1){1'b1}}} : low;
    end
  end

  // output register with skid
  logic              out_valid_q, skid_valid_q;
  logic [DATA_W-1:0] out_val_q, skid_val_q;
  logic              out_sat_q, skid_sat_q;
  logic              take, arrive;

  assign en     = !skid_valid_q;
  assign arrive = fin.valid && en;
  assign take   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      out_valid_q  <= skid_valid_q | arrive;
      skid_valid_q <= 1'b0;
    end else if (arrive) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_val_q <= skid_valid_q ? skid_val_q : res_val;
      out_sat_q <= skid_valid_q ? skid_sat_q : res_sat;
    end else if (arrive) begin
      skid_val_q <= res_val;
      skid_sat_q <= res_sat;
    end
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign measure_value_o = out_val_q;
  assign saturated_o     = out_sat_q;

  ap_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (measure_value_o == 32'h7fffffff || measure_value_o == 32'h80000000))
    else $error("saturated item without a range limit value");

  ap_skid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while the output register is empty");

  ap_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("skid item lost during output stall");

endmodule
